// ===== src/ftl_pkg.sv =====
`timescale 1ns / 1ps
// package for the flow table lookup and insert block
// holds the flow key type, hash constants, round function, status codes and fsm states
package ftl_pkg;

    // default table geometry; buckets must be a power of two, at most 1048576
    localparam int FTL_BUCKETS    = 4096;
    localparam int FTL_WAYS       = 4;
    localparam int FTL_MAX_BUCKETS = 1048576;

    localparam int KEY_W      = 96;
    localparam int HASH_W     = 32;
    localparam int MIX_ROUNDS = 6;
    localparam int OUT_DATA_W = 48;
    localparam int OUT_BKT_W  = 12;
    localparam int OUT_WAY_W  = 2;

    localparam logic [31:0] MIX_C0 = 32'h7ed55d16;
    localparam logic [31:0] MIX_C1 = 32'hc761c23c;
    localparam logic [31:0] MIX_C2 = 32'h165667b1;
    localparam logic [31:0] MIX_C3 = 32'hd3a2646c;
    localparam logic [31:0] MIX_C4 = 32'hfd7046c5;
    localparam logic [31:0] MIX_C5 = 32'hb55a4f09;

    // first member sits in the high bits, so src_addr lands in bits 31:0
    typedef struct packed {
        logic [15:0] dst_port;
        logic [15:0] src_port;
        logic [31:0] dst_addr;
        logic [31:0] src_addr;
    } t_flow_key;

    typedef enum logic [1:0] {
        STS_FOUND    = 2'd0,
        STS_INSERTED = 2'd1,
        STS_FULL     = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        LK_CLEAR,
        LK_IDLE,
        LK_CMP
    } t_lk_state;

    // memory control from the lookup sequencer to the table store
    typedef struct packed {
        logic rd_en;
        logic fill_we;
        logic key_we;
    } t_store_ctl;

    // one round of the six-round integer mix
    function automatic logic [31:0] mix_round(input logic [2:0] rnd, input logic [31:0] v);
        logic [31:0] r;
        case (rnd)
            3'd0:    r = (v + MIX_C0) + (v << 12);
            3'd1:    r = (v ^ MIX_C1) ^ (v >> 19);
            3'd2:    r = (v + MIX_C2) + (v << 5);
            3'd3:    r = (v + MIX_C3) ^ (v << 9);
            3'd4:    r = (v + MIX_C4) + (v << 3);
            3'd5:    r = (v ^ MIX_C5) ^ (v >> 16);
            default: r = v;
        endcase
        return r;
    endfunction

endpackage

// ===== src/ftl_hash.sv =====
`timescale 1ns / 1ps
// key hash pipeline: one mix round per stage on all three words, then the sum
// depends on ftl_pkg
module ftl_hash
    import ftl_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  t_flow_key         i_key,
    output logic              o_vld,
    output logic [HASH_W-1:0] o_hash,
    output t_flow_key         o_key
);

    logic [MIX_ROUNDS-1:0] r_vld;
    t_flow_key             r_key [MIX_ROUNDS];
    logic [31:0]           r_wa  [MIX_ROUNDS];
    logic [31:0]           r_wb  [MIX_ROUNDS];
    logic [31:0]           r_wc  [MIX_ROUNDS];
    logic [31:0]           in_a  [MIX_ROUNDS];
    logic [31:0]           in_b  [MIX_ROUNDS];
    logic [31:0]           in_c  [MIX_ROUNDS];

    logic                  r_sum_vld;
    logic [HASH_W-1:0]     r_hash;
    t_flow_key             r_sum_key;

    assign in_a[0] = i_key.src_addr;
    assign in_b[0] = i_key.dst_addr;
    assign in_c[0] = {i_key.src_port, i_key.dst_port};

    for (genvar k = 0; k < MIX_ROUNDS; k++) begin : g_round
        if (k > 0) begin : g_link
            assign in_a[k] = r_wa[k-1];
            assign in_b[k] = r_wb[k-1];
            assign in_c[k] = r_wc[k-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= (k == 0) ? i_vld : r_vld[(k > 0) ? k - 1 : 0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_wa[k]  <= mix_round(3'(k), in_a[k]);
                r_wb[k]  <= mix_round(3'(k), in_b[k]);
                r_wc[k]  <= mix_round(3'(k), in_c[k]);
                r_key[k] <= (k == 0) ? i_key : r_key[(k > 0) ? k - 1 : 0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_vld <= 1'b0;
        end else if (i_en) begin
            r_sum_vld <= r_vld[MIX_ROUNDS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hash    <= r_wa[MIX_ROUNDS-1] + r_wb[MIX_ROUNDS-1] + r_wc[MIX_ROUNDS-1];
            r_sum_key <= r_key[MIX_ROUNDS-1];
        end
    end

    assign o_vld  = r_sum_vld;
    assign o_hash = r_hash;
    assign o_key  = r_sum_key;

endmodule

// ===== src/ftl_store.sv =====
`timescale 1ns / 1ps
// table store: per-bucket fill counts and per-bucket rows of stored keys
// synchronous memories with registered read data; depends on ftl_pkg
module ftl_store
    import ftl_pkg::*;
#(
    parameter int BUCKETS = FTL_BUCKETS,
    parameter int WAYS    = FTL_WAYS,
    localparam int BKT_W  = $clog2(BUCKETS),
    localparam int FILL_W = $clog2(WAYS + 1),
    localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1
) (
    input  logic                        i_clk,
    input  t_store_ctl                  i_ctl,
    input  logic [BKT_W-1:0]            i_rd_bucket,
    input  logic [BKT_W-1:0]            i_wr_bucket,
    input  logic [WAY_W-1:0]            i_wr_way,
    input  logic [FILL_W-1:0]           i_wr_fill,
    input  t_flow_key                   i_wr_key,
    output logic [FILL_W-1:0]           o_rd_fill,
    output logic [WAYS-1:0][KEY_W-1:0]  o_rd_keys
);

    logic [FILL_W-1:0] r_fill_mem [BUCKETS];
    logic [KEY_W-1:0]  r_key_mem  [BUCKETS][WAYS];
    logic [FILL_W-1:0] r_rd_fill;

    always_ff @(posedge i_clk) begin
        if (i_ctl.fill_we) begin
            r_fill_mem[i_wr_bucket] <= i_wr_fill;
        end
        if (i_ctl.rd_en) begin
            r_rd_fill <= r_fill_mem[i_rd_bucket];
        end
    end

    // one row per bucket, written one way at a time
    for (genvar w = 0; w < WAYS; w++) begin : g_way
        always_ff @(posedge i_clk) begin
            if (i_ctl.key_we && (i_wr_way == WAY_W'(w))) begin
                r_key_mem[i_wr_bucket][w] <= i_wr_key;
            end
            if (i_ctl.rd_en) begin
                o_rd_keys[w] <= r_key_mem[i_rd_bucket][w];
            end
        end
    end

    assign o_rd_fill = r_rd_fill;

endmodule

// ===== src/ftl_match.sv =====
`timescale 1ns / 1ps
// bucket compare: matches the key against the filled ways, picks the first hit
// or the next free way; depends on ftl_pkg
module ftl_match
    import ftl_pkg::*;
#(
    parameter int WAYS    = FTL_WAYS,
    localparam int FILL_W = $clog2(WAYS + 1),
    localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1
) (
    input  logic [WAYS-1:0][KEY_W-1:0] i_keys,
    input  logic [FILL_W-1:0]          i_fill,
    input  t_flow_key                  i_key,
    output logic                       o_insert,
    output t_status                    o_status,
    output logic [WAY_W-1:0]           o_way
);

    logic [WAYS-1:0]  hit_vec;
    logic [WAY_W-1:0] hit_way;
    logic             found;

    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            hit_vec[w] = (FILL_W'(w) < i_fill) && (i_keys[w] == i_key);
        end
    end

    // lowest matching way wins
    always_comb begin
        hit_way = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (hit_vec[w]) begin
                hit_way = WAY_W'(w);
            end
        end
    end

    assign found    = |hit_vec;
    assign o_insert = !found && (i_fill != FILL_W'(WAYS));

    always_comb begin
        if (found) begin
            o_status = STS_FOUND;
            o_way    = hit_way;
        end else if (o_insert) begin
            o_status = STS_INSERTED;
            o_way    = i_fill[WAY_W-1:0];
        end else begin
            o_status = STS_FULL;
            o_way    = '0;
        end
    end

endmodule

// ===== src/flow_table_lookup_insert_top.sv =====
`timescale 1ns / 1ps
// top level of the flow table lookup and insert block
// uses ftl_pkg, ftl_hash, ftl_store and ftl_match
//
// usage
//   input stream s_axis: one transaction per flow key (addresses and ports).
//   output stream m_axis: one transaction per key, giving the status (found,
//   inserted or bucket full), the bucket, the way and the full 32-bit hash.
//   results come out in input order, exactly one per key.
// pipeline and ordering
//   the hash runs in a 7-stage pipeline (six mix rounds, then the sum). the
//   table side reads the bucket row and fill count in the idle state, and
//   compares, writes back and loads the output register in the compare
//   state. the read-then-write on the fill and key memories means the
//   table side takes no new key until the last one has left compare.
//   a write always lands before the next read issues, so back-to-back keys
//   hitting the same bucket need no forwarding.
// reset
//   after i_rst_n the fill memory is swept to zero, one bucket per cycle,
//   across all BUCKETS buckets (4096 by default); s_axis_tready stays low
//   until the sweep is done. stored keys are never cleared.
// stall
//   a result waits in the output register while m_axis_tready is low and the
//   key behind it holds in compare; once the next hashed key reaches the end
//   of the hash pipeline, the whole pipeline holds and s_axis_tready drops.
module flow_table_lookup_insert_top
    import ftl_pkg::*;
#(
    parameter int BUCKETS = FTL_BUCKETS,   // power of two, 2 to 1048576
    parameter int WAYS    = FTL_WAYS       // 1 to 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input key stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // src_addr[31:0], dst_addr[63:32], src_port[79:64], dst_port[95:80]
    input  logic [KEY_W-1:0]      s_axis_tdata,
    // result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // status[1:0], bucket_index[13:2], way_index[15:14], hash_value[47:16]
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int BKT_W  = $clog2(BUCKETS);
    localparam int FILL_W = $clog2(WAYS + 1);
    localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
    // bucket_index shows the bucket masked to its 12-bit field
    localparam logic [OUT_BKT_W-1:0] BIDX_MASK = OUT_BKT_W'((32'd1 << BKT_W) - 32'd1);

    // hash pipeline side
    logic              pipe_en;
    logic              hash_vld;
    logic [HASH_W-1:0] hash_val;
    t_flow_key         hash_key;

    // lookup sequencer
    t_lk_state         r_state;
    t_lk_state         n_state;
    logic [BKT_W-1:0]  r_clr_cnt;
    logic              clr_last;
    logic              take;
    logic              done;
    t_store_ctl        st_ctl;
    logic [BKT_W-1:0]  wr_bucket;
    logic [FILL_W-1:0] wr_fill;

    // item under lookup
    logic [HASH_W-1:0] r_hash;
    t_flow_key         r_key;

    // store read data and compare result
    logic [FILL_W-1:0]          rd_fill;
    logic [WAYS-1:0][KEY_W-1:0] rd_keys;
    logic                       m_insert;
    t_status                    m_status;
    logic [WAY_W-1:0]           m_way;
    logic [31:0]                way_ext;

    // output register
    logic                  r_out_vld;
    logic [OUT_DATA_W-1:0] r_out_data;

    // ---------------------------------------------------------------
    // input handshake and hash pipeline
    // ---------------------------------------------------------------
    // the pipeline moves whenever its last stage is empty or being taken
    assign pipe_en       = !hash_vld || take;
    assign s_axis_tready = pipe_en && (r_state != LK_CLEAR);

    ftl_hash u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_vld   (s_axis_tvalid && s_axis_tready),
        .i_key   (t_flow_key'(s_axis_tdata)),
        .o_vld   (hash_vld),
        .o_hash  (hash_val),
        .o_key   (hash_key)
    );

    // ---------------------------------------------------------------
    // lookup sequencer: clear sweep, bucket read, compare and write back
    // ---------------------------------------------------------------
    assign clr_last = (r_clr_cnt == BKT_W'(BUCKETS - 1));
    // result can leave the compare stage once the output register is free
    assign done     = (r_state == LK_CMP) && (!r_out_vld || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= LK_CLEAR;
            r_clr_cnt <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == LK_CLEAR) begin
                r_clr_cnt <= r_clr_cnt + BKT_W'(1);
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            LK_CLEAR: begin
                if (clr_last) begin
                    n_state = LK_IDLE;
                end
            end
            LK_IDLE: begin
                if (hash_vld) begin
                    n_state = LK_CMP;
                end
            end
            LK_CMP: begin
                if (done) begin
                    n_state = LK_IDLE;
                end
            end
            default: n_state = LK_CLEAR;
        endcase
    end

    // sequencer outputs
    always_comb begin
        take      = 1'b0;
        st_ctl    = '0;
        wr_bucket = r_hash[BKT_W-1:0];
        wr_fill   = rd_fill + FILL_W'(1);
        case (r_state)
            LK_CLEAR: begin
                st_ctl.fill_we = 1'b1;
                wr_bucket      = r_clr_cnt;
                wr_fill        = '0;
            end
            LK_IDLE: begin
                take          = hash_vld;
                st_ctl.rd_en  = hash_vld;
            end
            LK_CMP: begin
                st_ctl.fill_we = done && m_insert;
                st_ctl.key_we  = done && m_insert;
            end
            default: begin
                take = 1'b0;
            end
        endcase
    end

    // hold the key and hash while its bucket is read and compared
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_hash <= hash_val;
            r_key  <= hash_key;
        end
    end

    ftl_store #(
        .BUCKETS (BUCKETS),
        .WAYS    (WAYS)
    ) u_store (
        .i_clk       (i_clk),
        .i_ctl       (st_ctl),
        .i_rd_bucket (hash_val[BKT_W-1:0]),
        .i_wr_bucket (wr_bucket),
        .i_wr_way    (m_way),
        .i_wr_fill   (wr_fill),
        .i_wr_key    (r_key),
        .o_rd_fill   (rd_fill),
        .o_rd_keys   (rd_keys)
    );

    ftl_match #(
        .WAYS (WAYS)
    ) u_match (
        .i_keys   (rd_keys),
        .i_fill   (rd_fill),
        .i_key    (r_key),
        .o_insert (m_insert),
        .o_status (m_status),
        .o_way    (m_way)
    );

    // ---------------------------------------------------------------
    // output register
    // ---------------------------------------------------------------
    assign way_ext = 32'(m_way);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (done) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_out_data <= {r_hash,
                           way_ext[OUT_WAY_W-1:0],
                           r_hash[OUT_BKT_W-1:0] & BIDX_MASK,
                           m_status};
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
`ifndef ASSERT_OFF
    a_no_input_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == LK_CLEAR) |-> !s_axis_tready)
        else $error("key transaction taken during fill clear sweep");

    a_read_then_compare: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        st_ctl.rd_en |=> (r_state == LK_CMP))
        else $error("bucket read not followed by compare");

    a_fill_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == LK_CMP) |-> (rd_fill <= FILL_W'(WAYS)))
        else $error("bucket fill count above way count");

    a_out_from_compare: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> ($past(r_state) == LK_CMP))
        else $error("result appeared without a finished compare");

    a_key_write_with_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        st_ctl.key_we |-> (st_ctl.fill_we && done && (m_status == STS_INSERTED)))
        else $error("key written without fill update");
`endif

endmodule
